[src/max_square_map_prune_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the maximal square map block
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef MAX_SQUARE_MAP_PRUNE_ASSERT_SVH
`define MAX_SQUARE_MAP_PRUNE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MSPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MSPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/mspr_pkg.sv]
// ----------------------------------------------------------------------------
// mspr_pkg
// Field widths, register indexes and the result type of the maximal square
// map block.
// ----------------------------------------------------------------------------
`default_nettype none

package mspr_pkg;

  localparam int unsigned POS_W     = 10;
  localparam int unsigned SIZE_W    = 11;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // One reported pixel as it leaves the block.
  typedef struct packed {
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [SIZE_W-1:0] square;
    logic [SIZE_W-1:0] pruned;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

[src/max_square_map_prune.sv]
// A pixel's results are formed in the compute stage and registered in the output buffer.
// Throughput: one pixel per cycle while each pixel yields at most one result and
// the output is not stalled; a pixel with more results (two at a row end, up to
// four in the last row) holds the output port until the single result port drains them.
// Reset (rst_n low, synchronous) clears counters, neighbor registers and output
// valids and sets both frame dimensions to 1024; the line buffer is not cleared.
// ----------------------------------------------------------------------------
// max_square_map_prune
// Streaming maximal square map with pruning of pixels that have a larger
// right, lower or lower-right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module max_square_map_prune #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // Configuration write port.
  input  wire                               cfg_we,
  input  wire  [mspr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [mspr_pkg::CFG_W-1:0]        cfg_data,
  // Pixel input channel.
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               in_pixel,
  // Result channel.
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [mspr_pkg::POS_W-1:0]        out_row,
  output logic [mspr_pkg::POS_W-1:0]        out_col,
  output logic [mspr_pkg::SIZE_W-1:0]       out_square_size,
  output logic [mspr_pkg::SIZE_W-1:0]       out_pruned_size,
  output logic                              out_last
);

  import mspr_pkg::*;

  // CW indexes a row or column, SW holds a square size up to MAX_DIM, and XW
  // is wide enough for both the clamped dimensions and the raw register value.
  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned SW = $clog2(MAX_DIM + 1);
  localparam int unsigned XW = (SW > CFG_W) ? SW : CFG_W;
  localparam int unsigned NRES = 4;

  // --------------------------------------------------------------------------
  // Configuration registers and their clamped values.
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] frame_width_r;
  logic [CFG_W-1:0] frame_height_r;
  logic [XW-1:0]    w_eff;
  logic [XW-1:0]    h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_DIM_RESET;
      frame_height_r <= CFG_DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // A dimension of zero acts as one, and one above MAX_DIM acts as MAX_DIM.
  always_comb begin
    w_eff = XW'(frame_width_r);
    h_eff = XW'(frame_height_r);
    if (w_eff == '0) begin
      w_eff = XW'(1);
    end else if (w_eff > XW'(MAX_DIM)) begin
      w_eff = XW'(MAX_DIM);
    end
    if (h_eff == '0) begin
      h_eff = XW'(1);
    end else if (h_eff > XW'(MAX_DIM)) begin
      h_eff = XW'(MAX_DIM);
    end
  end

  // --------------------------------------------------------------------------
  // Position tracking. The position of an incoming pixel is settled at its
  // transaction, including the wrap that follows a frame resize.
  // --------------------------------------------------------------------------
  logic [CW-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [CW-1:0] cur_row, cur_col;
  logic          cur_last_row, cur_last_col;

  always_comb begin
    cur_row = row_cnt_r;
    cur_col = col_cnt_r;
    // A row count at or past the height starts a new frame.
    if (XW'(row_cnt_r) >= h_eff) begin
      cur_row = '0;
      cur_col = '0;
    end
    // A column count at or past the width starts the next row.
    if (XW'(cur_col) >= w_eff) begin
      cur_col = '0;
      if (XW'(cur_row) + XW'(1) >= h_eff) begin
        cur_row = '0;
      end else begin
        cur_row = cur_row + CW'(1);
      end
    end

    cur_last_row = (XW'(cur_row) + XW'(1) == h_eff);
    cur_last_col = (XW'(cur_col) + XW'(1) == w_eff);

    if (cur_last_col || (XW'(cur_col) + XW'(1) > w_eff)) begin
      col_cnt_nxt = '0;
      if (XW'(cur_row) + XW'(1) >= h_eff) begin
        row_cnt_nxt = '0;
      end else begin
        row_cnt_nxt = cur_row + CW'(1);
      end
    end else begin
      col_cnt_nxt = cur_col + CW'(1);
      row_cnt_nxt = cur_row;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. The compute stage hands its results to the output buffer only
  // when the buffer is empty or gives up its final entry in this cycle.
  // --------------------------------------------------------------------------
  logic             s1_valid_r;
  logic             s1_fire;
  logic             can_load;
  logic             in_acc;
  logic             out_acc;
  logic [NRES-1:0]  res_vld_r;
  logic [NRES-1:0]  sel_oh;
  logic [NRES-1:0]  res_left;

  assign out_valid = |res_vld_r;
  assign out_acc   = out_valid && !out_stall;
  assign res_left  = res_vld_r & ~sel_oh;
  assign can_load  = (res_vld_r == '0) || (out_acc && (res_left == '0));
  assign s1_fire   = s1_valid_r && can_load;
  assign in_stall  = s1_valid_r && !can_load;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r  <= '0;
      col_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        row_cnt_r  <= row_cnt_nxt;
        col_cnt_r  <= col_cnt_nxt;
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Compute stage registers: the pixel, its position and the line buffer entry
  // of the row above at its column.
  // --------------------------------------------------------------------------
  logic          s1_pix_r;
  logic [CW-1:0] s1_row_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_last_row_r;
  logic          s1_last_col_r;
  logic [SW-1:0] up_rd_r;
  logic [SW-1:0] ul_r;
  logic [SW-1:0] left_r;
  logic [SW-1:0] line_buf [MAX_DIM];

  logic [SW-1:0] ul_sz, up_sz, left_sz, min_sz, m_sz;
  logic [SW:0]   m_inc;
  logic          first_row, first_col;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r      <= in_pixel;
      s1_row_r      <= cur_row;
      s1_col_r      <= cur_col;
      s1_last_row_r <= cur_last_row;
      s1_last_col_r <= cur_last_col;
    end
  end

  // Line buffer: the compute stage writes the new size at its column, and the
  // incoming pixel reads its column. When both hit the same column in one
  // cycle (a one-pixel-wide frame) the new size is forwarded.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      line_buf[s1_col_r] <= m_sz;
    end
    if (in_acc) begin
      if (s1_fire && (s1_col_r == cur_col)) begin
        up_rd_r <= m_sz;
      end else begin
        up_rd_r <= line_buf[cur_col];
      end
    end
  end

  always_comb begin
    first_row = (s1_row_r == '0);
    first_col = (s1_col_r == '0);
    ul_sz     = (first_row || first_col) ? '0 : ul_r;
    up_sz     = first_row ? '0 : up_rd_r;
    left_sz   = first_col ? '0 : left_r;

    min_sz = ul_sz;
    if (up_sz < min_sz) begin
      min_sz = up_sz;
    end
    if (left_sz < min_sz) begin
      min_sz = left_sz;
    end
    m_inc = {1'b0, min_sz} + (SW + 1)'(1);

    if (!s1_pix_r) begin
      m_sz = '0;
    end else if (m_inc > (SW + 1)'(MAX_DIM)) begin
      m_sz = SW'(MAX_DIM);
    end else begin
      m_sz = m_inc[SW-1:0];
    end
  end

  // Left and up-left neighbors for the next pixel of the row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ul_r   <= '0;
      left_r <= '0;
    end else if (s1_fire) begin
      ul_r   <= up_sz;
      left_r <= m_sz;
    end
  end

  // --------------------------------------------------------------------------
  // Candidate results, in output order: the up-left pixel, the pixel above at
  // a row end, the left pixel in the last row, and this pixel at the frame end.
  // --------------------------------------------------------------------------
  res_t            res_c [NRES];
  logic [NRES-1:0] cand_vld;
  logic            seen;

  always_comb begin
    cand_vld[0] = !first_row && !first_col;
    cand_vld[1] = !first_row && s1_last_col_r;
    cand_vld[2] = s1_last_row_r && !first_col;
    cand_vld[3] = s1_last_row_r && s1_last_col_r;

    res_c[0].row    = POS_W'(s1_row_r - CW'(1));
    res_c[0].col    = POS_W'(s1_col_r - CW'(1));
    res_c[0].square = SIZE_W'(ul_sz);
    res_c[0].pruned = ((up_sz > ul_sz) || (left_sz > ul_sz) || (m_sz > ul_sz)) ?
                      '0 : SIZE_W'(ul_sz);

    res_c[1].row    = POS_W'(s1_row_r - CW'(1));
    res_c[1].col    = POS_W'(s1_col_r);
    res_c[1].square = SIZE_W'(up_sz);
    res_c[1].pruned = (m_sz > up_sz) ? '0 : SIZE_W'(up_sz);

    res_c[2].row    = POS_W'(s1_row_r);
    res_c[2].col    = POS_W'(s1_col_r - CW'(1));
    res_c[2].square = SIZE_W'(left_sz);
    res_c[2].pruned = (m_sz > left_sz) ? '0 : SIZE_W'(left_sz);

    res_c[3].row    = POS_W'(s1_row_r);
    res_c[3].col    = POS_W'(s1_col_r);
    res_c[3].square = SIZE_W'(m_sz);
    res_c[3].pruned = SIZE_W'(m_sz);

    // The highest valid candidate closes the pixel's group of results.
    seen = 1'b0;
    for (int k = NRES - 1; k >= 0; k--) begin
      res_c[k].last = cand_vld[k] && !seen;
      seen          = seen || cand_vld[k];
    end
  end

  // --------------------------------------------------------------------------
  // Output buffer: one pixel's results, drained lowest entry first.
  // --------------------------------------------------------------------------
  res_t       res_q_r [NRES];
  logic [1:0] sel;

  always_comb begin
    priority if (res_vld_r[0]) begin
      sel = 2'd0;
    end else if (res_vld_r[1]) begin
      sel = 2'd1;
    end else if (res_vld_r[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    sel_oh = NRES'(1) << sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= '0;
    end else if (s1_fire) begin
      res_vld_r <= cand_vld;
    end else if (out_acc) begin
      res_vld_r <= res_left;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_q_r <= res_c;
    end
  end

  assign out_row         = res_q_r[sel].row;
  assign out_col         = res_q_r[sel].col;
  assign out_square_size = res_q_r[sel].square;
  assign out_pruned_size = res_q_r[sel].pruned;
  assign out_last        = res_q_r[sel].last;

endmodule

`default_nettype wire

[src/mspr_checker.sv]
// ----------------------------------------------------------------------------
// mspr_checker
// Port-level checks for the maximal square map block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_square_map_prune_assert.svh"

module mspr_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               cfg_we,
  input wire [mspr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input wire [mspr_pkg::CFG_W-1:0]         cfg_data,
  input wire                               in_valid,
  input wire                               in_stall,
  input wire                               in_pixel,
  input wire                               out_valid,
  input wire                               out_stall,
  input wire [mspr_pkg::POS_W-1:0]         out_row,
  input wire [mspr_pkg::POS_W-1:0]         out_col,
  input wire [mspr_pkg::SIZE_W-1:0]        out_square_size,
  input wire [mspr_pkg::SIZE_W-1:0]        out_pruned_size,
  input wire                               out_last
);

  import mspr_pkg::*;

  logic unused_ok;
  assign unused_ok = cfg_we ^ (|cfg_index) ^ (|cfg_data) ^ in_valid ^ in_pixel;

  // A stalled result transaction holds its payload.
  `MSPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_row) && $stable(out_col) && $stable(out_square_size) && $stable(out_pruned_size) && $stable(out_last), "stalled result changed")

  // A pruned size is either zero or the square size itself.
  `MSPR_ASSERT_NOW(a_prune_value, out_valid, (out_pruned_size == '0) || (out_pruned_size == out_square_size), "pruned size is neither zero nor the square size")

  // A result that does not close its group is followed by another result.
  `MSPR_ASSERT_NEXT(a_group_cont, out_valid && !out_last, out_valid, "result group ended without last")

  // Input is held back only while results are waiting at the output.
  `MSPR_ASSERT_NOW(a_stall_cause, in_stall, out_valid, "input stalled with no pending result")

endmodule

bind max_square_map_prune mspr_checker u_mspr_checker (.*);

`default_nettype wire

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// Maximal square map testbench
// Streams binary frames through the block and checks every reported pixel
// against a cycle-free prediction of square sizes and pruning. Frame sizes
// cover the register extremes and mid-frame resizes, and both channels are
// throttled at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import mspr_pkg::*;

  localparam int unsigned MAX_DIM       = 1024;
  localparam int unsigned RANDOM_PIXELS = 180;
  // Cycles without any transaction on either channel before the run is
  // declared hung. The longest legal quiet stretch is the deliberate
  // receiver hold-off below plus a run of random stalls.
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;

  // Holds the predicted state of the block and the pixel reports still due.
  class square_map_scoreboard;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [SIZE_W-1:0] line_sizes [MAX_DIM];
    int unsigned       diag_size;
    int unsigned       left_size;
    int unsigned       row_pos;
    int unsigned       col_pos;
    res_t              reports_due [$];
    int unsigned       errors;

    function new();
      width_reg  = CFG_DIM_RESET;
      height_reg = CFG_DIM_RESET;
      foreach (line_sizes[i]) line_sizes[i] = '0;
      diag_size = 0;
      left_size = 0;
      row_pos   = 0;
      col_pos   = 0;
      errors    = 0;
    endfunction

    // A dimension of zero behaves as one, anything past MAX_DIM as MAX_DIM.
    function int unsigned dim(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_FRAME_WIDTH:  width_reg = v;
        REG_FRAME_HEIGHT: height_reg = v;
        default: ;
      endcase
    endfunction

    function res_t make_report(int unsigned r, int unsigned c, int unsigned sq,
                               int unsigned pr);
      res_t t;
      t.row    = r[POS_W-1:0];
      t.col    = c[POS_W-1:0];
      t.square = sq[SIZE_W-1:0];
      t.pruned = pr[SIZE_W-1:0];
      t.last   = 1'b0;
      return t;
    endfunction

    // Pixels still needed to reach the next frame boundary; a whole frame
    // when standing at one.
    function int unsigned pixels_to_frame_end();
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      w = dim(width_reg);
      h = dim(height_reg);
      r = row_pos;
      c = col_pos;
      if (r >= h) begin
        r = 0;
        c = 0;
      end
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      return w * h - (r * w + c);
    endfunction

    // Advances the predicted state by one accepted pixel and queues the
    // reports that this pixel completes.
    function void note_pixel(logic pix);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      int unsigned ul;
      int unsigned up;
      int unsigned lf;
      int unsigned m;
      int unsigned n;
      res_t        step_reports [4];
      w = dim(width_reg);
      h = dim(height_reg);
      n = 0;
      // A shrunken frame may leave the position outside it.
      if (row_pos >= h) begin
        row_pos = 0;
        col_pos = 0;
      end
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      if (c == 0) begin
        diag_size = 0;
        left_size = 0;
      end
      ul = (r == 0) ? 0 : diag_size;
      up = (r == 0) ? 0 : line_sizes[c];
      lf = left_size;
      if (pix) begin
        m = ul;
        if (up < m) m = up;
        if (lf < m) m = lf;
        m++;
        if (m > MAX_DIM) m = MAX_DIM;
      end else begin
        m = 0;
      end

      // The up-left pixel now has all three later neighbors known.
      if (r > 0 && c > 0)
        step_reports[n++] = make_report(r - 1, c - 1, ul,
                                        (up > ul || lf > ul || m > ul) ? 0 : ul);
      if (r > 0 && c == w - 1)
        step_reports[n++] = make_report(r - 1, c, up, (m > up) ? 0 : up);
      if (r == h - 1 && c > 0)
        step_reports[n++] = make_report(r, c - 1, lf, (m > lf) ? 0 : lf);
      if (r == h - 1 && c == w - 1)
        step_reports[n++] = make_report(r, c, m, m);
      if (n > 0) step_reports[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) reports_due.push_back(step_reports[i]);

      line_sizes[c] = m[SIZE_W-1:0];
      diag_size = up;
      left_size = m;
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
        if (row_pos >= h) row_pos = 0;
        diag_size = 0;
        left_size = 0;
      end
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_report(res_t got);
      res_t want;
      if (reports_due.size() == 0) begin
        $error("unexpected report: row %0d col %0d", got.row, got.col);
        errors++;
        return;
      end
      want = reports_due.pop_front();
      compare_field("out_row", want.row, got.row);
      compare_field("out_col", want.col, got.col);
      compare_field("out_square_size", want.square, got.square);
      compare_field("out_pruned_size", want.pruned, got.pruned);
      compare_field("out_last", want.last, got.last);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_pixel = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [POS_W-1:0]   out_row;
  logic [POS_W-1:0]   out_col;
  logic [SIZE_W-1:0]  out_square_size;
  logic [SIZE_W-1:0]  out_pruned_size;
  logic               out_last;

  // Throttling in percent per cycle, changed by the stimulus between phases.
  int unsigned send_idle_pct = 29;
  int unsigned stall_pct     = 78;
  // Cycles the receiver still has to hold off in one unbroken stretch.
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  square_map_scoreboard sb = new();

  max_square_map_prune #(
    .MAX_DIM(MAX_DIM)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_square_size(out_square_size),
    .out_pruned_size(out_pruned_size),
    .out_last       (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: stalls at random, or for a whole requested stretch. All
  // inputs change at the falling edge so the rising edge sees them settled.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Both channels are observed at the rising edge, where a transaction
  // completes. Input transactions feed the prediction, output transactions
  // are checked against it. A long quiet stretch means the block hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_pixel(in_pixel);
      if (out_valid && !out_stall)
        sb.check_report({out_row, out_col, out_square_size, out_pruned_size, out_last});
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("max_square_map_prune test failed");
        $finish;
      end
    end
  end

  // Offers one pixel and returns at the falling edge after its transaction.
  // Valid stays high on return, so the caller either offers the next pixel
  // or lowers valid within the same time step.
  task automatic send_pixel(input logic pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends a run of pixels, then lowers valid and returns at the falling edge after
  // that, so the next run starts in a time step of its own.
  task automatic send_pixels(input int unsigned count, input int unsigned ones_pct);
    for (int unsigned i = 0; i < count; i++)
      send_pixel($urandom_range(99) < ones_pct);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every predicted report has arrived, then lets the block settle,
  // since the block may still be working on a pixel that reports nothing yet.
  task automatic wait_drained();
    while (sb.reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes both frame registers in back-to-back cycles while the block idles.
  task automatic set_frame(input int unsigned w, input int unsigned h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w[CFG_W-1:0];
    sb.write_reg(REG_FRAME_WIDTH, w[CFG_W-1:0]);
    @(negedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h[CFG_W-1:0];
    sb.write_reg(REG_FRAME_HEIGHT, h[CFG_W-1:0]);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned part;
    int unsigned density;
    int unsigned random_sent;
    bit          held;

    random_sent = 0;
    held = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. The first frame is wider than any later mid-frame
    // resize, so every line buffer entry such a resize can read is written.
    set_frame(16, 2);
    send_pixels(sb.pixels_to_frame_end(), 90);
    // Width above the maximum acts as the maximum: part of a single row.
    wait_drained();
    set_frame(2047, 1);
    send_pixels(12, 95);
    // Height of zero acts as one; the width cut opens a new frame.
    wait_drained();
    set_frame(4, 0);
    send_pixels(sb.pixels_to_frame_end(), 50);
    // Width of zero acts as one.
    wait_drained();
    set_frame(0, 3);
    send_pixels(sb.pixels_to_frame_end(), 95);
    // Height above the maximum acts as the maximum; cutting the height
    // below the current row then opens a new frame.
    wait_drained();
    set_frame(3, 2047);
    send_pixels(9, 90);
    wait_drained();
    set_frame(3, 2);
    send_pixels(sb.pixels_to_frame_end(), 90);
    // One-pixel frames: a set pixel, then a clear one.
    wait_drained();
    set_frame(1, 1);
    send_pixels(1, 100);
    send_pixels(1, 0);
    // Solid and empty frames: squares grow along the diagonal and all but
    // the lower-right corner get pruned, or everything stays zero.
    wait_drained();
    set_frame(4, 4);
    send_pixels(16, 100);
    send_pixels(16, 0);
    // Height cut below the current row: the next pixel opens a new frame.
    wait_drained();
    set_frame(6, 5);
    send_pixels(8, 80);
    wait_drained();
    set_frame(6, 1);
    send_pixels(sb.pixels_to_frame_end(), 80);
    // Width cut below the current column: the next pixel opens a new row.
    wait_drained();
    set_frame(8, 4);
    send_pixels(13, 90);
    wait_drained();
    set_frame(3, 4);
    send_pixels(sb.pixels_to_frame_end(), 90);

    // Random part: whole frames of random size and density, some of them
    // resized partway through. Each third of it uses its own throttling.
    while (random_sent < RANDOM_PIXELS) begin
      if (random_sent < RANDOM_PIXELS / 3) begin
        send_idle_pct = 29;
        stall_pct = 78;
      end else if (random_sent < 2 * RANDOM_PIXELS / 3) begin
        send_idle_pct = 78;
        stall_pct = 29;
      end else begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      w = ($urandom_range(7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      h = (w > 10) ? $urandom_range(1, 3) : $urandom_range(1, 8);
      case ($urandom_range(3))
        0:       density = 50;
        1:       density = 80;
        default: density = 95;
      endcase
      // Once, with the sender at full rate, the receiver holds off long
      // enough for the block to fill up and stall its input.
      if (stall_pct == 0 && !held) begin
        w = 20;
        h = 3;
      end

      wait_drained();
      set_frame(w, h);
      if (stall_pct == 0 && !held) begin
        hold_left = 80;
        held = 1'b1;
      end
      total = w * h;
      if (total > 1 && $urandom_range(4) == 0) begin
        // Stop partway, let every report come out, then resize.
        part = $urandom_range(1, total - 1);
        send_pixels(part, density);
        random_sent += part;
        wait_drained();
        set_frame($urandom_range(1, 10), $urandom_range(1, 8));
        total = sb.pixels_to_frame_end();
      end
      send_pixels(total, density);
      random_sent += total;
    end

    while (sb.reports_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("max_square_map_prune test passed");
    end else begin
      $display("max_square_map_prune test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+src
src/mspr_pkg.sv
src/max_square_map_prune.sv
src/mspr_checker.sv
sim/testbench.sv
